@@ rtl/core/lps_pkg.sv @@
// Shared types, codes and constant pose tables for the legged pose sequencer.
// Depends on nothing; every other file imports it.
`default_nettype none

package lps_pkg;

    localparam int NUM_JOINTS      = 12;
    localparam int JOINT_W         = 4;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int PROGRESS_W      = 16;
    localparam int GAIN_W          = 16;
    localparam int STEP_W          = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 17;
    localparam int CMD_W           = 3;
    localparam int MODE_W          = 3;
    localparam int KEY_W           = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_KEY      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FEEDBACK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TARGET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHUT_OFF = 3'd4;

    // Modes
    localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRONE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STANDING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STAND    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WALKING  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PRONING  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RECOVERY = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAND_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALKING_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRONING_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRONE_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STANDING_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRONING_STEP  = 3'd6;

    localparam logic [GAIN_W-1:0] STAND_GAIN_RST    = 16'd25600;
    localparam logic [GAIN_W-1:0] WALKING_GAIN_RST  = 16'd6400;
    localparam logic [GAIN_W-1:0] PRONING_GAIN_RST  = 16'd6400;
    localparam logic [GAIN_W-1:0] PRONE_GAIN_RST    = 16'd1280;
    localparam logic [GAIN_W-1:0] DAMPING_GAIN_RST  = 16'd256;
    localparam logic [STEP_W-1:0] STANDING_STEP_RST = 17'd328;
    localparam logic [STEP_W-1:0] PRONING_STEP_RST  = 17'd328;

    localparam logic [KEY_W-1:0] KEY_SPACE     = 16'd32;
    localparam logic [KEY_W-1:0] KEY_PAD_START = 16'd4;

    // ceil(2^17 / 3): exact floor division by three for 17-bit numerators
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    typedef logic signed [15:0] angle_t;
    typedef angle_t pose_t [NUM_JOINTS];

    // Hundredths of a radian to Q(15-F).F, halves away from zero, saturated.
    function automatic angle_t angle_of(input int cs);
        int mag;
        int v;
        mag = (cs < 0) ? -cs : cs;
        v = (mag * (1 << ANGLE_FRAC_BITS) + 50) / 100;
        if (cs < 0) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return angle_t'(v);
    endfunction

    localparam pose_t PRONE_POSE = '{
        angle_of(-35), angle_of(136), angle_of(-265), angle_of(35), angle_of(136),
        angle_of(-265), angle_of(-35), angle_of(136), angle_of(-265), angle_of(35),
        angle_of(136), angle_of(-265)};
    localparam pose_t STAND_POSE = '{
        angle_of(-10), angle_of(80), angle_of(-150), angle_of(10), angle_of(80),
        angle_of(-150), angle_of(-10), angle_of(100), angle_of(-150), angle_of(10),
        angle_of(100), angle_of(-150)};
    localparam pose_t RESCUE_POSE = '{
        angle_of(-30), angle_of(100), angle_of(-185), angle_of(30), angle_of(100),
        angle_of(-185), angle_of(-30), angle_of(123), angle_of(-215), angle_of(30),
        angle_of(123), angle_of(-215)};
    localparam pose_t LO_LIM = '{
        angle_of(-104), angle_of(-52), angle_of(-272), angle_of(-104), angle_of(-52),
        angle_of(-272), angle_of(-104), angle_of(-52), angle_of(-272), angle_of(-104),
        angle_of(-52), angle_of(-272)};
    localparam pose_t HI_LIM = '{
        angle_of(104), angle_of(453), angle_of(-83), angle_of(104), angle_of(453),
        angle_of(-83), angle_of(104), angle_of(453), angle_of(-83), angle_of(104),
        angle_of(453), angle_of(-83)};

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [KEY_W-1:0]   key_code;
        logic               from_controller;
        logic [JOINT_W-1:0] joint_number;
        angle_t             joint_angle;
    } in_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] out_joint;
        angle_t             position;
        logic [GAIN_W-1:0]  stiffness;
        logic [GAIN_W-1:0]  damping;
        logic               motor_off;
        logic [MODE_W-1:0]  robot_mode;
        logic               last_joint;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic               key_evt;
        logic               meas_wr;
        logic               tgt_wr;
        logic               tick_adv;
        logic               shut;
        logic               issue;
        logic [JOINT_W-1:0] joint;
        logic               last;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_ready;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/lps_ctrl.sv @@
// Controller: accepts input beats, decodes commands, sequences the twelve
// joint issues of a tick or shut-off. Depends on lps_pkg.
`default_nettype none

module lps_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [lps_pkg::CMD_W-1:0] command,
    input  wire lps_pkg::dp_status_t       status,
    output lps_pkg::ctrl_cmd_t             cmd
);
    import lps_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic               state_reg, state_next;
    logic [JOINT_W-1:0] cnt_reg, cnt_next;
    logic               accept;
    logic               is_last;

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        accept  = s_valid && s_ready;
        is_last = (cnt_reg == JOINT_W'(NUM_JOINTS - 1));

        cmd          = '0;
        cmd.joint    = cnt_reg;
        cmd.last     = is_last;
        cmd.issue    = (state_reg == ST_EMIT) && status.pipe_ready;

        state_next = state_reg;
        cnt_next   = cnt_reg;

        if (accept) begin
            unique case (command)
                CMD_TICK: begin
                    cmd.tick_adv = 1'b1;
                    state_next   = ST_EMIT;
                    cnt_next     = '0;
                end
                CMD_KEY:      cmd.key_evt = 1'b1;
                CMD_FEEDBACK: cmd.meas_wr = 1'b1;
                CMD_TARGET:   cmd.tgt_wr  = 1'b1;
                CMD_SHUT_OFF: begin
                    cmd.shut   = 1'b1;
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                default: ;
            endcase
        end

        // advance one joint per issue, back to idle after the last one
        if (cmd.issue) begin
            if (is_last) begin
                state_next = ST_IDLE;
            end else begin
                cnt_next = cnt_reg + JOINT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lps_datapath.sv @@
// Datapath: configuration registers, mode and progress state, pose stores and
// the two-step joint command pipeline. Depends on lps_pkg.
`default_nettype none

module lps_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire lps_pkg::in_item_t              s_data,
    input  wire lps_pkg::ctrl_cmd_t             cmd,
    input  wire logic                           out_free,
    output lps_pkg::dp_status_t                 status,
    output logic                                res_valid,
    output lps_pkg::out_item_t                  res_data
);
    import lps_pkg::*;

    // configuration
    logic [GAIN_W-1:0] stand_gain_reg, walking_gain_reg, proning_gain_reg;
    logic [GAIN_W-1:0] prone_gain_reg, damping_gain_reg;
    logic [STEP_W-1:0] standing_step_reg, proning_step_reg;

    // sequencer state
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [PROGRESS_W-1:0] progress_reg, progress_next;
    pose_t                 measured_reg, target_reg, start_reg;
    logic                  change_mode;

    // mode transition logic
    logic                  go;
    logic [STEP_W-1:0]     step;
    logic [PROGRESS_W+1:0] psum;
    logic                  blending;

    // issue stage
    angle_t            goal, cur_start;
    logic signed [16:0] diff;
    logic [16:0]       mag;
    logic [32:0]       prod;
    logic [32:0]       k3_prod;
    angle_t            fixed_pos;
    logic [GAIN_W-1:0] kp;

    // stage 1 registers
    logic                  s1_valid_reg, s1_valid_next;
    logic [32:0]           s1_prod_reg;
    logic                  s1_neg_reg, s1_blend_reg, s1_off_reg, s1_last_reg;
    angle_t                s1_start_reg, s1_fixed_reg;
    logic [GAIN_W-1:0]     s1_kp_reg, s1_kd_reg;
    logic [MODE_W-1:0]     s1_mode_reg;
    logic [JOINT_W-1:0]    s1_joint_reg;

    // result stage
    logic [33:0]        rsum;
    logic [16:0]        r;
    logic signed [17:0] blend_w;
    angle_t             pos_sel, pos_out;

    // ---------------------------------------------------------------- modes
    always_comb begin
        go = s_data.from_controller ? (s_data.key_code == KEY_PAD_START)
                                    : (s_data.key_code == KEY_SPACE);
        blending = (mode_reg == MODE_STANDING) || (mode_reg == MODE_PRONING);
        step = (mode_reg == MODE_STANDING) ? standing_step_reg : proning_step_reg;
        if (step == '0) step = STEP_W'(1);
        psum = (PROGRESS_W + 2)'(progress_reg) + (PROGRESS_W + 2)'(step);

        mode_next     = mode_reg;
        progress_next = progress_reg;
        change_mode   = 1'b0;

        if (cmd.key_evt && (s_data.key_code != '0)) begin
            change_mode = 1'b1;
            unique case (mode_reg)
                MODE_OFF:      if (go) mode_next = MODE_PRONE; else change_mode = 1'b0;
                MODE_PRONE:    if (go) mode_next = MODE_STANDING; else change_mode = 1'b0;
                MODE_STANDING: if (!go) mode_next = MODE_PRONING; else change_mode = 1'b0;
                MODE_STAND:    mode_next = go ? MODE_WALKING : MODE_PRONING;
                MODE_WALKING:  mode_next = go ? MODE_STAND : MODE_RECOVERY;
                MODE_RECOVERY: mode_next = go ? MODE_STANDING : MODE_PRONING;
                default:       change_mode = 1'b0;
            endcase
            if (change_mode &&
                ((mode_next == MODE_STANDING) || (mode_next == MODE_PRONING))) begin
                progress_next = '0;
            end
        end else if (cmd.tick_adv && blending) begin
            if (psum[PROGRESS_W+1:PROGRESS_W] != 2'b00) begin
                // progress reached one: land in the goal mode
                change_mode   = 1'b1;
                mode_next     = (mode_reg == MODE_STANDING) ? MODE_STAND : MODE_PRONE;
                progress_next = '0;
            end else begin
                progress_next = psum[PROGRESS_W-1:0];
            end
        end else if (cmd.shut) begin
            change_mode = 1'b1;
            mode_next   = MODE_OFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stand_gain_reg    <= STAND_GAIN_RST;
            walking_gain_reg  <= WALKING_GAIN_RST;
            proning_gain_reg  <= PRONING_GAIN_RST;
            prone_gain_reg    <= PRONE_GAIN_RST;
            damping_gain_reg  <= DAMPING_GAIN_RST;
            standing_step_reg <= STANDING_STEP_RST;
            proning_step_reg  <= PRONING_STEP_RST;
            mode_reg          <= MODE_OFF;
            progress_reg      <= '0;
            measured_reg      <= PRONE_POSE;
            start_reg         <= PRONE_POSE;
            target_reg        <= STAND_POSE;
            s1_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_STAND_GAIN:    stand_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                    REG_WALKING_GAIN:  walking_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_PRONING_GAIN:  proning_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_PRONE_GAIN:    prone_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                    REG_DAMPING_GAIN:  damping_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_STANDING_STEP: standing_step_reg <= cfg_wdata[STEP_W-1:0];
                    REG_PRONING_STEP:  proning_step_reg  <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            mode_reg     <= mode_next;
            progress_reg <= progress_next;
            if (change_mode) start_reg <= measured_reg;
            if (cmd.meas_wr && (s_data.joint_number < JOINT_W'(NUM_JOINTS))) begin
                measured_reg[s_data.joint_number] <= s_data.joint_angle;
            end
            if (cmd.tgt_wr && (s_data.joint_number < JOINT_W'(NUM_JOINTS))) begin
                target_reg[s_data.joint_number] <= s_data.joint_angle;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    // ---------------------------------------------------------- issue stage
    always_comb begin
        cur_start = start_reg[cmd.joint];
        goal = (mode_reg == MODE_STANDING) ? STAND_POSE[cmd.joint] : PRONE_POSE[cmd.joint];
        diff = 17'(goal) - 17'(cur_start);
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        prod = 33'(mag) * 33'(progress_reg);
        // back joints while proning: round(2g/3) as floor((2g+1)/3)
        k3_prod = 33'({proning_gain_reg, 1'b1}) * 33'(DIV3_RECIP);

        case (mode_reg)
            MODE_PRONE:    fixed_pos = PRONE_POSE[cmd.joint];
            MODE_STAND:    fixed_pos = STAND_POSE[cmd.joint];
            MODE_WALKING:  fixed_pos = target_reg[cmd.joint];
            MODE_RECOVERY: fixed_pos = RESCUE_POSE[cmd.joint];
            default:       fixed_pos = '0;
        endcase

        case (mode_reg) inside
            MODE_PRONE:                              kp = prone_gain_reg;
            MODE_STANDING, MODE_STAND, MODE_RECOVERY: kp = stand_gain_reg;
            MODE_WALKING:                            kp = walking_gain_reg;
            MODE_PRONING: begin
                if (cmd.joint < JOINT_W'(NUM_JOINTS / 2)) kp = proning_gain_reg;
                else kp = k3_prod[DIV3_SHIFT +: GAIN_W];
            end
            default:                                 kp = '0;
        endcase

        status.pipe_ready = !s1_valid_reg || out_free;
        s1_valid_next = cmd.issue ? 1'b1 : ((s1_valid_reg && out_free) ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            s1_prod_reg  <= prod;
            s1_neg_reg   <= diff[16];
            s1_start_reg <= cur_start;
            s1_fixed_reg <= fixed_pos;
            s1_blend_reg <= blending;
            s1_kp_reg    <= kp;
            s1_kd_reg    <= (mode_reg == MODE_OFF) ? '0 : damping_gain_reg;
            s1_off_reg   <= (mode_reg == MODE_OFF);
            s1_mode_reg  <= mode_reg;
            s1_joint_reg <= cmd.joint;
            s1_last_reg  <= cmd.last;
        end
    end

    // --------------------------------------------------------- result stage
    always_comb begin
        rsum    = 34'(s1_prod_reg) + 34'(32768);
        r       = rsum[32:16];
        blend_w = 18'(s1_start_reg) + (s1_neg_reg ? -$signed({1'b0, r}) : $signed({1'b0, r}));
        pos_sel = s1_blend_reg ? angle_t'(blend_w[15:0]) : s1_fixed_reg;
        if (s1_off_reg) begin
            pos_out = '0;
        end else if (pos_sel < LO_LIM[s1_joint_reg]) begin
            pos_out = LO_LIM[s1_joint_reg];
        end else if (pos_sel > HI_LIM[s1_joint_reg]) begin
            pos_out = HI_LIM[s1_joint_reg];
        end else begin
            pos_out = pos_sel;
        end

        res_valid           = s1_valid_reg;
        res_data.out_joint  = s1_joint_reg;
        res_data.position   = pos_out;
        res_data.stiffness  = s1_kp_reg;
        res_data.damping    = s1_kd_reg;
        res_data.motor_off  = s1_off_reg;
        res_data.robot_mode = s1_mode_reg;
        res_data.last_joint = s1_last_reg;
    end

endmodule

`default_nettype wire

@@ rtl/core/legged_pose_mode_sequencer.sv @@
// The first command beat of a tick goes through the stage 1 and output registers.
// A tick or shut-off holds the input until its twelve joint issues are done, which output
//   backpressure can stall; key, feedback and target beats do not hold the input.
// The controller's joint issue loop issues one joint per cycle while the pipeline is ready.
// Reset (aresetn low, synchronous): mode off, progress zero, poses and registers to defaults.
// Top level: ties the controller and datapath together and holds the output register.
`default_nettype none

module legged_pose_mode_sequencer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire lps_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output lps_pkg::out_item_t                  m_data
);
    import lps_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       res_valid;
    out_item_t  res_data;

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg;
    logic       out_free;
    logic       load;

    // Controller: owns the input handshake and walks the joints of a tick.
    lps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .command (s_data.command),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: state updates on accepted beats, per-joint command pipeline.
    lps_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .out_free  (out_free),
        .status    (status),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Output register: take a new beat when empty or when the current one leaves.
    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        load         = res_valid && out_free;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_valid      = m_valid_reg;
        m_data       = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the payload until the beat is taken
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_legged_pose_mode_sequencer.sv @@
// Self-checking bench for legged_pose_mode_sequencer: a directed stimulus table, then
// random phases under several register settings, checked beat by beat against a pose predictor.
// Depends on rtl/core/lps_pkg.sv and rtl/core/legged_pose_mode_sequencer.sv.
`timescale 1ns / 1ps

module tb_legged_pose_mode_sequencer;
    import lps_pkg::*;

    localparam int          STALL_LIMIT    = 4000;   // cycles without any accepted beat
    localparam int          SETTLE_CYCLES  = 6;      // extra wait after every owed beat has arrived
    localparam int          PROGRESS_FULL  = 1 << PROGRESS_W;
    localparam int          PHASE_ITEMS    = 25;
    localparam int          MAX_REPORTS    = 40;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    // How a directed row gets its expected beats.
    typedef enum logic [1:0] {BY_MODEL, LIT_OFF, LIT_NONE} row_exp_t;

    typedef struct {
        in_item_t beat;
        row_exp_t how;
    } stim_row_t;

    typedef struct {
        int unsigned stand_gain;
        int unsigned walking_gain;
        int unsigned proning_gain;
        int unsigned prone_gain;
        int unsigned damping_gain;
        int unsigned standing_step;
        int unsigned proning_step;
    } reg_set_t;

    // ---------------------------------------------------------------- DUT and its ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    legged_pose_mode_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- pose predictor
    // Pose tables in hundredths of a radian; converted to Q3.12 on use.
    int lie_cs    [12] = '{-35, 136, -265, 35, 136, -265, -35, 136, -265, 35, 136, -265};
    int up_cs     [12] = '{-10, 80, -150, 10, 80, -150, -10, 100, -150, 10, 100, -150};
    int rescue_cs [12] = '{-30, 100, -185, 30, 100, -185, -30, 123, -215, 30, 123, -215};
    int lim_lo_cs [3]  = '{-104, -52, -272};
    int lim_hi_cs [3]  = '{104, 453, -83};

    logic [MODE_W-1:0] pm_mode;
    int unsigned       pm_progress;
    int                pm_meas  [NUM_JOINTS];
    int                pm_tgt   [NUM_JOINTS];
    int                pm_start [NUM_JOINTS];
    int unsigned       cfg_val  [7];
    out_item_t         pred_cmds [NUM_JOINTS];

    out_item_t joint_cmd_q [$];     // command beats still owed by the DUT
    int        mism_count = 0;
    int        beat_no    = 0;

    // Hundredths of a radian to Q3.12: round half away from zero, saturate to 16 bits.
    function automatic int cs_to_q(input int cs);
        int mag;
        int q;
        mag = (cs < 0) ? -cs : cs;
        q = (mag * (1 << ANGLE_FRAC_BITS) + 50) / 100;
        if (cs < 0) q = -q;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic void reset_pose_state();
        pm_mode     = MODE_OFF;
        pm_progress = 0;
        for (int i = 0; i < NUM_JOINTS; i++) begin
            pm_meas[i]  = cs_to_q(lie_cs[i]);
            pm_start[i] = cs_to_q(lie_cs[i]);
            pm_tgt[i]   = cs_to_q(up_cs[i]);
        end
        cfg_val[REG_STAND_GAIN]    = 32'(STAND_GAIN_RST);
        cfg_val[REG_WALKING_GAIN]  = 32'(WALKING_GAIN_RST);
        cfg_val[REG_PRONING_GAIN]  = 32'(PRONING_GAIN_RST);
        cfg_val[REG_PRONE_GAIN]    = 32'(PRONE_GAIN_RST);
        cfg_val[REG_DAMPING_GAIN]  = 32'(DAMPING_GAIN_RST);
        cfg_val[REG_STANDING_STEP] = 32'(STANDING_STEP_RST);
        cfg_val[REG_PRONING_STEP]  = 32'(PRONING_STEP_RST);
    endfunction

    // Any mode change latches the measured pose as the new start pose.
    function automatic void switch_mode(input logic [MODE_W-1:0] next);
        if (next == MODE_STANDING || next == MODE_PRONING) pm_progress = 0;
        pm_start = pm_meas;
        pm_mode  = next;
    endfunction

    function automatic void take_key(input logic [KEY_W-1:0] key, input logic pad);
        bit go;
        if (key == '0) return;
        go = pad ? (key == KEY_PAD_START) : (key == KEY_SPACE);
        case (pm_mode)
            MODE_OFF:      if (go) switch_mode(MODE_PRONE);
            MODE_PRONE:    if (go) switch_mode(MODE_STANDING);
            MODE_STANDING: if (!go) switch_mode(MODE_PRONING);
            MODE_STAND:    switch_mode(go ? MODE_WALKING : MODE_PRONING);
            MODE_WALKING:  switch_mode(go ? MODE_STAND : MODE_RECOVERY);
            MODE_RECOVERY: switch_mode(go ? MODE_STANDING : MODE_PRONING);
            default: ;
        endcase
    endfunction

    // Advance the rise or lie-down blend, then build the twelve joint commands.
    function automatic void emit_tick();
        int          blend [NUM_JOINTS];
        int          diff;
        longint      mag;
        longint      r;
        int          pos;
        int unsigned kp;
        int unsigned kd;
        int unsigned stepv;
        bit          rising;
        blend  = pm_start;
        rising = (pm_mode == MODE_STANDING);
        if (rising || pm_mode == MODE_PRONING) begin
            stepv = rising ? cfg_val[REG_STANDING_STEP] : cfg_val[REG_PRONING_STEP];
            if (stepv == 0) stepv = 1;
            pm_progress += stepv;
            if (pm_progress > PROGRESS_FULL) pm_progress = PROGRESS_FULL;
            for (int i = 0; i < NUM_JOINTS; i++) begin
                diff = cs_to_q(rising ? up_cs[i] : lie_cs[i]) - pm_start[i];
                mag  = (diff < 0) ? -diff : diff;
                r    = (mag * pm_progress + 32768) >> 16;
                blend[i] = pm_start[i] + ((diff < 0) ? -int'(r) : int'(r));
            end
            if (pm_progress >= PROGRESS_FULL) begin
                switch_mode(rising ? MODE_STAND : MODE_PRONE);
                pm_progress = 0;
            end
        end
        for (int i = 0; i < NUM_JOINTS; i++) begin
            pos = 0;
            kp  = 0;
            kd  = cfg_val[REG_DAMPING_GAIN];
            case (pm_mode)
                MODE_PRONE: begin
                    pos = cs_to_q(lie_cs[i]);
                    kp  = cfg_val[REG_PRONE_GAIN];
                end
                MODE_STANDING: begin
                    pos = blend[i];
                    kp  = cfg_val[REG_STAND_GAIN];
                end
                MODE_STAND: begin
                    pos = cs_to_q(up_cs[i]);
                    kp  = cfg_val[REG_STAND_GAIN];
                end
                MODE_WALKING: begin
                    pos = pm_tgt[i];
                    kp  = cfg_val[REG_WALKING_GAIN];
                end
                MODE_PRONING: begin
                    pos = blend[i];
                    // back legs run at two thirds of the proning gain, rounded
                    kp  = (i < NUM_JOINTS / 2) ? cfg_val[REG_PRONING_GAIN]
                                               : (2 * cfg_val[REG_PRONING_GAIN] + 1) / 3;
                end
                MODE_RECOVERY: begin
                    pos = cs_to_q(rescue_cs[i]);
                    kp  = cfg_val[REG_STAND_GAIN];
                end
                default: kd = 0;
            endcase
            if (pm_mode != MODE_OFF) begin
                if (pos < cs_to_q(lim_lo_cs[i % 3])) pos = cs_to_q(lim_lo_cs[i % 3]);
                else if (pos > cs_to_q(lim_hi_cs[i % 3])) pos = cs_to_q(lim_hi_cs[i % 3]);
            end
            pred_cmds[i].out_joint  = JOINT_W'(i);
            pred_cmds[i].position   = angle_t'(pos);
            pred_cmds[i].stiffness  = kp[GAIN_W-1:0];
            pred_cmds[i].damping    = kd[GAIN_W-1:0];
            pred_cmds[i].motor_off  = (pm_mode == MODE_OFF);
            pred_cmds[i].robot_mode = pm_mode;
            pred_cmds[i].last_joint = (i == NUM_JOINTS - 1);
        end
    endfunction

    // Apply one accepted input beat; returns how many command beats it produces.
    function automatic int sequence_pose(input in_item_t it);
        int n;
        n = 0;
        case (it.command)
            CMD_TICK: begin
                emit_tick();
                n = NUM_JOINTS;
            end
            CMD_KEY: take_key(it.key_code, it.from_controller);
            CMD_FEEDBACK: if (it.joint_number < NUM_JOINTS)
                pm_meas[it.joint_number] = int'($signed(it.joint_angle));
            CMD_TARGET: if (it.joint_number < NUM_JOINTS)
                pm_tgt[it.joint_number] = int'($signed(it.joint_angle));
            CMD_SHUT_OFF: begin
                switch_mode(MODE_OFF);
                emit_tick();
                n = NUM_JOINTS;
            end
            default: ;
        endcase
        return n;
    endfunction

    // ---------------------------------------------------------------- checking
    task automatic flag_mismatch(input string what, input int got, input int want);
        mism_count++;
        if (mism_count <= MAX_REPORTS)
            $display("ERROR @%0t beat %0d %s: got %0d, wanted %0d", $realtime, beat_no, what,
                     got, want);
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (joint_cmd_q.size() == 0) begin
            flag_mismatch("beat with nothing owed, joint", int'(got.out_joint), -1);
            return;
        end
        want = joint_cmd_q.pop_front();
        if (got.out_joint !== want.out_joint)
            flag_mismatch("out_joint", int'(got.out_joint), int'(want.out_joint));
        if (got.position !== want.position)
            flag_mismatch("position", int'(got.position), int'(want.position));
        if (got.stiffness !== want.stiffness)
            flag_mismatch("stiffness", int'(got.stiffness), int'(want.stiffness));
        if (got.damping !== want.damping)
            flag_mismatch("damping", int'(got.damping), int'(want.damping));
        if (got.motor_off !== want.motor_off)
            flag_mismatch("motor_off", int'(got.motor_off), int'(want.motor_off));
        if (got.robot_mode !== want.robot_mode)
            flag_mismatch("robot_mode", int'(got.robot_mode), int'(want.robot_mode));
        if (got.last_joint !== want.last_joint)
            flag_mismatch("last_joint", int'(got.last_joint), int'(want.last_joint));
        beat_no++;
    endtask

    // Receiver: pick a stall style for a stretch of cycles, then hold it.
    int rdy_style = 0;
    int rdy_left  = 0;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_beat(m_data);
        if (rdy_left == 0) begin
            rdy_style = $urandom_range(0, 3);
            rdy_left  = $urandom_range(8, 60);
        end else begin
            rdy_left--;
        end
        case (rdy_style)
            0: m_ready <= 1'b1;                              // no backpressure
            1: m_ready <= ($urandom_range(0, 1) == 1);       // coin flip
            2: m_ready <= ($urandom_range(0, 3) == 0);       // mostly stalled
            default: m_ready <= (rdy_left % 3 != 0);         // regular two-of-three
        endcase
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sender
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // Offer one beat; hold valid and payload until accepted, then book its expectations.
    task automatic push_item(input in_item_t it, input row_exp_t how);
        int        n;
        out_item_t off_cmd;
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) burst_left--;
        n = sequence_pose(it);
        if (how == BY_MODEL) begin
            for (int i = 0; i < n; i++) joint_cmd_q.push_back(pred_cmds[i]);
        end else if (how == LIT_OFF) begin
            // motors off: stop markers, zero gains, same for every joint
            for (int i = 0; i < NUM_JOINTS; i++) begin
                off_cmd            = '0;
                off_cmd.out_joint  = JOINT_W'(i);
                off_cmd.motor_off  = 1'b1;
                off_cmd.robot_mode = MODE_OFF;
                off_cmd.last_joint = (i == NUM_JOINTS - 1);
                joint_cmd_q.push_back(off_cmd);
            end
        end
    endtask

    // Drop valid, wait out every owed beat plus the pipeline tail.
    task automatic settle();
        s_valid <= 1'b0;
        while (joint_cmd_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        int unsigned kept;
        kept = (idx == REG_STANDING_STEP || idx == REG_PRONING_STEP) ? (val & 32'h1_FFFF)
                                                                      : (val & 32'hFFFF);
        cfg_wr_en    <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= val[CFG_DATA_W-1:0];
        cfg_val[idx] = kept;
        @(posedge aclk);
    endtask

    task automatic load_settings(input reg_set_t r);
        put_reg(REG_STAND_GAIN,    r.stand_gain);
        put_reg(REG_WALKING_GAIN,  r.walking_gain);
        put_reg(REG_PRONING_GAIN,  r.proning_gain);
        put_reg(REG_PRONE_GAIN,    r.prone_gain);
        put_reg(REG_DAMPING_GAIN,  r.damping_gain);
        put_reg(REG_STANDING_STEP, r.standing_step);
        put_reg(REG_PRONING_STEP,  r.proning_step);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned rnd_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic int unsigned rnd_step();
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, PROGRESS_FULL);
        return $urandom_range(8000, 40000);
    endfunction

    function automatic stim_row_t mk_row(input logic [CMD_W-1:0] cmd,
                                         input logic [KEY_W-1:0] key, input logic pad,
                                         input logic [JOINT_W-1:0] joint, input int angle,
                                         input row_exp_t how);
        stim_row_t r;
        r.beat.command         = cmd;
        r.beat.key_code        = key;
        r.beat.from_controller = pad;
        r.beat.joint_number    = joint;
        r.beat.joint_angle     = angle_t'(angle);
        r.how                  = how;
        return r;
    endfunction

    // Random beat, biased toward start keys and ticks so runs climb through the modes.
    function automatic in_item_t rand_item();
        in_item_t it;
        int       pick;
        it.key_code        = KEY_W'($urandom_range(0, 16'hFFFF));
        it.from_controller = 1'($urandom_range(0, 1));
        it.joint_number    = JOINT_W'($urandom_range(0, 15));
        it.joint_angle     = angle_t'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.command = CMD_TICK;
        end else if (pick < 65) begin
            it.command = CMD_KEY;
            pick = $urandom_range(0, 9);
            if (pick < 6) it.key_code = it.from_controller ? KEY_PAD_START : KEY_SPACE;
            else if (pick == 9) it.key_code = '0;
        end else if (pick < 92) begin
            it.command = (pick < 80) ? CMD_FEEDBACK : CMD_TARGET;
            if ($urandom_range(0, 9) != 0)
                it.joint_number = JOINT_W'($urandom_range(0, NUM_JOINTS - 1));
            if ($urandom_range(0, 1) == 1)
                it.joint_angle = angle_t'(int'($urandom_range(0, 24000)) - 12000);
        end else if (pick < 96) begin
            it.command = CMD_SHUT_OFF;
        end else begin
            it.command = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- main sequence
    stim_row_t dir_rows [25];

    initial begin
        reg_set_t r;
        in_item_t it;
        int       useful;
        reset_pose_state();
        dir_rows = '{
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      LIT_OFF),  // reset: off
            mk_row(CMD_LAST_UNUSED, 16'hFFFF,      1'b1, 4'd15, -1,     LIT_NONE), // bad command
            mk_row(CMD_KEY,         '0,            1'b0, 4'd0,  0,      LIT_NONE), // no key
            mk_row(CMD_KEY,         KEY_SPACE,     1'b0, 4'd0,  0,      LIT_NONE), // off -> prone
            mk_row(CMD_FEEDBACK,    '0,            1'b0, 4'd15, 32767,  LIT_NONE), // bad joint
            mk_row(CMD_FEEDBACK,    '0,            1'b0, 4'd0,  -32768, LIT_NONE),
            mk_row(CMD_FEEDBACK,    '0,            1'b0, 4'd11, 32767,  LIT_NONE),
            mk_row(CMD_TARGET,      '0,            1'b0, 4'd0,  32767,  LIT_NONE),
            mk_row(CMD_TARGET,      '0,            1'b0, 4'd11, -32768, LIT_NONE),
            mk_row(CMD_TARGET,      '0,            1'b0, 4'd12, 0,      LIT_NONE), // bad joint
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      BY_MODEL), // prone pose
            mk_row(CMD_KEY,         KEY_PAD_START, 1'b1, 4'd0,  0,      LIT_NONE), // -> standing
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      BY_MODEL), // blend, clamp
            mk_row(CMD_KEY,         KEY_SPACE,     1'b1, 4'd0,  0,      LIT_NONE), // pad abort
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      BY_MODEL), // proning gains
            mk_row(CMD_KEY,         KEY_SPACE,     1'b0, 4'd0,  0,      LIT_NONE), // ignored
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      BY_MODEL),
            mk_row(CMD_SHUT_OFF,    '0,            1'b0, 4'd0,  0,      LIT_OFF),
            mk_row(CMD_KEY,         KEY_PAD_START, 1'b0, 4'd0,  0,      LIT_NONE), // abort in off
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      LIT_OFF),
            mk_row(CMD_KEY,         KEY_PAD_START, 1'b1, 4'd0,  0,      LIT_NONE), // -> prone
            mk_row(CMD_KEY,         16'hFFFF,      1'b1, 4'd0,  0,      LIT_NONE), // abort, prone
            mk_row(CMD_TICK,        '0,            1'b0, 4'd0,  0,      BY_MODEL),
            mk_row(CMD_KEY,         KEY_SPACE,     1'b0, 4'd0,  0,      LIT_NONE), // -> standing
            mk_row(CMD_SHUT_OFF,    '0,            1'b0, 4'd0,  0,      LIT_OFF)
        };

        // Hold reset low, then release it once.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part runs on the reset register values.
        foreach (dir_rows[k]) push_item(dir_rows[k].beat, dir_rows[k].how);

        // Random phases, each under its own register setting; extremes first.
        for (int ph = 1; ph <= 6; ph++) begin
            settle();
            case (ph)
                1: r = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         PROGRESS_FULL, PROGRESS_FULL};
                2: r = '{0, 0, 0, 0, 0, 0, 0};          // zero steps crawl like a step of one
                3: r = '{rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(),
                         17'h1_FFFF, 17'h1_FFFF};       // overshoot, saturate at one
                5: r = '{rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(),
                         21845, 16384};
                default: r = '{rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(), rnd_gain(),
                               rnd_step(), rnd_step()};
            endcase
            load_settings(r);
            gaps_on = ($urandom_range(0, 2) != 0);
            useful  = 0;
            while (useful < PHASE_ITEMS) begin
                it = rand_item();
                push_item(it, BY_MODEL);
                // unused commands and zero keys do not count toward the phase
                if (it.command <= CMD_SHUT_OFF && !(it.command == CMD_KEY && it.key_code == '0))
                    useful++;
            end
        end

        settle();
        if (mism_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lps_pkg.sv
rtl/core/lps_ctrl.sv
rtl/core/lps_datapath.sv
rtl/core/legged_pose_mode_sequencer.sv
sim/tb_legged_pose_mode_sequencer.sv
